[rtl/skrf_pkg.sv]
// Shared constants, widths and the sequencer state type of the range filter.
package skrf_pkg;

  // Default number of fraction bits in the mean and variance words.
  localparam int unsigned FRAC_BITS = 12;

  // Fraction bits of the incoming Q12.4 distance.
  localparam int unsigned DIST_FRAC = 4;

  localparam int unsigned DIST_W  = 16;  // distance sample
  localparam int unsigned RVAR_W  = 10;  // measurement variance register
  localparam int unsigned VAL_W   = 32;  // mean and variance words
  localparam int unsigned RF_W    = 30;  // R shifted into Q.F
  localparam int unsigned DEN_W   = 33;  // P + R
  localparam int unsigned MAG_W   = 34;  // |z - mu| and multiplier B operand
  localparam int unsigned HALF_W  = MAG_W / 2;
  localparam int unsigned PART_W  = VAL_W + HALF_W;
  localparam int unsigned PROD_W  = VAL_W + MAG_W;
  localparam int unsigned QUO_W   = MAG_W;
  localparam int unsigned UPD_W   = 36;  // updated mean before predict
  localparam int unsigned VSUM_W  = QUO_W + 1;
  localparam int unsigned MEAN_W  = UPD_W + 1;

  localparam int unsigned MEAN_RESET_WHOLE = 400;
  localparam int unsigned VAR_RESET_WHOLE  = 10000;
  localparam int unsigned PROC_VAR_SCALE   = 10;
  localparam int unsigned RVAR_RESET       = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_MAG,
    ST_MUL_VAR,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } skrf_state_e;

endpackage

[rtl/scalar_kalman_range_filter.sv]
// Top level of the scalar Kalman range filter: sequencer, state and result register.
//
//   Channel   Direction  Handshake                  Word
//   input     in         in_valid_i / in_ready_o    distance_i (Q12.4 cm)
//   result    out        out_valid_o / out_ready_i  est_mean_o, est_var_o (Q.F)
//   config    in         cfg_we_i                   cfg_wdata_i (R, whole cm^2)
//
// A word goes from the edge that accepts it through two passes through the
// shared multiplier, then the two-lane divider (34 one-bit steps, then its
// done flag), then the update and predict, which load the result register;
// only then can its result be taken. The block takes no new word until that
// work is done. Reset loads the estimate with a mean of 400 and a variance
// of 10000 and sets R to one.
// A stalled result register holds the finished word; the next word is
// accepted meanwhile and waits only at its last step.
module scalar_kalman_range_filter #(
  parameter int unsigned FracBits = skrf_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skrf_pkg::RVAR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [skrf_pkg::DIST_W-1:0]   distance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [skrf_pkg::VAL_W-1:0] est_mean_o,
  output logic [skrf_pkg::VAL_W-1:0]    est_var_o
);
  import skrf_pkg::*;

  localparam int unsigned VarRstWideW = VAL_W + 14;
  localparam logic [VarRstWideW-1:0] VarRstWide =
    VarRstWideW'(VAR_RESET_WHOLE) << FracBits;
  // The variance reset value saturates when it does not fit the word.
  localparam logic [VAL_W-1:0] VarRst =
    (|VarRstWide[VarRstWideW-1:VAL_W]) ? '1 : VarRstWide[VAL_W-1:0];
  localparam logic [VAL_W-1:0] MeanRst = VAL_W'(MEAN_RESET_WHOLE) << FracBits;

  skrf_state_e state_q, state_d;

  logic [RVAR_W-1:0]       rvar_q;
  logic signed [VAL_W-1:0] mean_q;
  logic [VAL_W-1:0]        var_q;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_mean_q;
  logic [VAL_W-1:0]        out_var_q;

  // Working registers of the word in flight.
  logic [VAL_W-1:0]        z_q;
  logic                    neg_q;
  logic [RF_W-1:0]         rf_q;
  logic [DEN_W-1:0]        den_q;
  logic [PROD_W-1:0]       prod_q;
  logic signed [UPD_W-1:0] upd_q;
  logic [VSUM_W-1:0]       vsum_q;

  // Control from the output decode.
  logic              accept;
  logic              mul_start;
  logic [MAG_W-1:0]  mul_b;
  logic              div_start;
  logic              fin;

  // Shared unit ports.
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              div_done;
  logic [QUO_W-1:0]  quo0, quo1;

  // Front-end arithmetic on the incoming word.
  logic [RVAR_W-1:0]       r_eff;
  logic [RF_W-1:0]         rf;
  logic [VAL_W-1:0]        z;
  logic [MAG_W-1:0]        diff;
  logic [MAG_W-1:0]        mag;
  logic [DEN_W-1:0]        den;

  // Back-end arithmetic.
  logic [MAG_W-1:0]         rf10;
  logic signed [MEAN_W-1:0] mean_full;
  logic signed [VAL_W-1:0]  mean_sat;
  logic [VAL_W-1:0]         var_sat;
  logic                     out_free;

  // A zero R is out of range and behaves as one.
  assign r_eff = (rvar_q == '0) ? RVAR_W'(1) : rvar_q;
  assign rf    = RF_W'(r_eff) << FracBits;
  assign z     = VAL_W'(distance_i) << (FracBits - DIST_FRAC);
  assign diff  = {2'b00, z} - {{(MAG_W - VAL_W){mean_q[VAL_W-1]}}, mean_q};
  assign mag   = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;
  assign den   = {1'b0, var_q} + DEN_W'(rf);

  assign rf10 = MAG_W'(rf_q) * MAG_W'(PROC_VAR_SCALE);

  // Predict: the motion term doubles the updated mean and removes z.
  assign mean_full = {upd_q, 1'b0} - MEAN_W'({1'b0, z_q});

  always_comb begin
    if (mean_full[MEAN_W-1:VAL_W-1] == '0 || mean_full[MEAN_W-1:VAL_W-1] == '1) begin
      mean_sat = mean_full[VAL_W-1:0];
    end else if (mean_full[MEAN_W-1]) begin
      mean_sat = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      mean_sat = {1'b0, {(VAL_W - 1){1'b1}}};
    end
  end

  assign var_sat  = (|vsum_q[VSUM_W-1:VAL_W]) ? '1 : vsum_q[VAL_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  // Next-state decode.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_MAG;
        end
      end
      ST_MUL_MAG: begin
        if (mul_done) begin
          state_d = ST_MUL_VAR;
        end
      end
      ST_MUL_VAR: begin
        if (mul_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready_o = 1'b0;
    accept     = 1'b0;
    mul_start  = 1'b0;
    mul_b      = mag;
    div_start  = 1'b0;
    fin        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        mul_start  = in_valid_i;
      end
      ST_MUL_MAG: begin
        mul_start = mul_done;
        mul_b     = MAG_W'(rf_q);
      end
      ST_MUL_VAR: begin
        div_start = mul_done;
      end
      ST_FIN: begin
        fin = out_free;
      end
      default: begin
      end
    endcase
  end

  skrf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (var_q),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Lane 0 forms the gain correction P*|z-mu|/(P+R), lane 1 forms P*R/(P+R).
  skrf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num0_i  (prod_q),
    .num1_i  (mul_prod),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo0_o  (quo0),
    .quo1_o  (quo1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rvar_q      <= RVAR_W'(RVAR_RESET);
      mean_q      <= MeanRst;
      var_q       <= VarRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rvar_q <= cfg_wdata_i;
      end
      if (fin) begin
        mean_q      <= mean_sat;
        var_q       <= var_sat;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      z_q   <= z;
      neg_q <= diff[MAG_W-1];
      rf_q  <= rf;
      den_q <= den;
    end
    if (state_q == ST_MUL_MAG && mul_done) begin
      prod_q <= mul_prod;
    end
    // The correction moves the mean toward the measurement.
    if (state_q == ST_UPD) begin
      if (neg_q) begin
        upd_q <= UPD_W'(mean_q) - UPD_W'(quo0);
      end else begin
        upd_q <= UPD_W'(mean_q) + UPD_W'(quo0);
      end
      vsum_q <= VSUM_W'(quo1) + VSUM_W'(rf10);
    end
    if (fin) begin
      out_mean_q <= mean_sat;
      out_var_q  <= var_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign est_mean_o  = out_mean_q;
  assign est_var_o   = out_var_q;

endmodule

[rtl/skrf_mul.sv]
// Shared multiplier: 32 by 34 bit product built from two 32 by 17 bit passes.
module skrf_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skrf_pkg::VAL_W-1:0]   a_i,
  input  logic [skrf_pkg::MAG_W-1:0]   b_i,
  output logic                         done_o,
  output logic [skrf_pkg::PROD_W-1:0]  prod_o
);
  import skrf_pkg::*;

  logic              s0_q, s1_q, s2_q, s3_q;
  logic [VAL_W-1:0]  a_q;
  logic [MAG_W-1:0]  b_q;
  logic [HALF_W-1:0] b_sel;
  logic [PART_W-1:0] part;
  logic [PART_W-1:0] lo_q, hi_q;
  logic [PROD_W-1:0] prod_q;

  // The low half of B goes through first, the high half in the cycle after.
  assign b_sel = s0_q ? b_q[HALF_W-1:0] : b_q[MAG_W-1:HALF_W];
  assign part  = PART_W'(a_q) * PART_W'(b_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= 1'b0;
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else begin
      s0_q <= start_i;
      s1_q <= s0_q;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (s0_q) begin
      lo_q <= part;
    end
    if (s1_q) begin
      hi_q <= part;
    end
    if (s2_q) begin
      prod_q <= (PROD_W'(hi_q) << HALF_W) + PROD_W'(lo_q);
    end
  end

  assign done_o = s3_q;
  assign prod_o = prod_q;

endmodule

[rtl/skrf_div.sv]
// Restoring divider with two lanes that share one divisor, one quotient bit per cycle.
module skrf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skrf_pkg::PROD_W-1:0]  num0_i,
  input  logic [skrf_pkg::PROD_W-1:0]  num1_i,
  input  logic [skrf_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [skrf_pkg::QUO_W-1:0]   quo0_o,
  output logic [skrf_pkg::QUO_W-1:0]   quo1_o
);
  import skrf_pkg::*;

  localparam int unsigned NumLanes = 2;
  localparam int unsigned CntW     = $clog2(QUO_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q [NumLanes];
  logic [QUO_W-1:0]   sh_q  [NumLanes];
  logic [DEN_W-1:0]   rem_d [NumLanes];
  logic [QUO_W-1:0]   sh_d  [NumLanes];
  logic [PROD_W-1:0]  num   [NumLanes];

  assign num[0] = num0_i;
  assign num[1] = num1_i;

  // The shift register feeds dividend bits out of its top and collects
  // quotient bits at its bottom; after QUO_W steps it holds the quotient.
  always_comb begin
    logic [DEN_W:0] rs;
    logic [DEN_W:0] diff;
    for (int l = 0; l < NumLanes; l++) begin
      rs   = {rem_q[l], sh_q[l][QUO_W-1]};
      diff = rs - {1'b0, den_q};
      if (rs >= {1'b0, den_q}) begin
        rem_d[l] = diff[DEN_W-1:0];
        sh_d[l]  = {sh_q[l][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[l] = rs[DEN_W-1:0];
        sh_d[l]  = {sh_q[l][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int l = 0; l < NumLanes; l++) begin
        rem_q[l] <= DEN_W'(num[l][PROD_W-1:QUO_W]);
        sh_q[l]  <= num[l][QUO_W-1:0];
      end
    end else if (busy_q) begin
      for (int l = 0; l < NumLanes; l++) begin
        rem_q[l] <= rem_d[l];
        sh_q[l]  <= sh_d[l];
      end
    end
  end

  assign done_o = done_q;
  assign quo0_o = sh_q[0];
  assign quo1_o = sh_q[1];

endmodule

[sim/scalar_kalman_range_filter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the scalar Kalman range filter, with its own estimate predictor.
module scalar_kalman_range_filter_tb;
  import skrf_pkg::*;

  localparam int unsigned NUM_ROWS    = 16;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_WORDS = 95;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned DRAIN_WAIT  = 64;   // idle margin after the last result
  localparam longint      MEAN_MAX    = 64'sd2147483647;
  localparam longint      MEAN_MIN    = -64'sd2147483648;

  // One result word: the estimate after the predict step.
  typedef struct packed {
    logic signed [VAL_W-1:0] mean;
    logic [VAL_W-1:0]        variance;
  } range_estimate_t;

  // One directed row. A row may first load R; only the first row carries a
  // hand-worked expectation, every other row is checked against the predictor.
  typedef struct packed {
    logic                    load_r;
    logic [RVAR_W-1:0]       r_value;
    logic [DIST_W-1:0]       range_cm;
    logic                    typed;
    logic signed [VAL_W-1:0] mean;
    logic [VAL_W-1:0]        variance;
  } stim_row_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [RVAR_W-1:0]       cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [DIST_W-1:0]       distance_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] est_mean_o;
  logic [VAL_W-1:0]        est_var_o;

  // Predictor state: the stored estimate and the measurement variance.
  logic signed [VAL_W-1:0] est_mean_q;
  logic [VAL_W-1:0]        est_var_q;
  logic [RVAR_W-1:0]       meas_var_q;

  range_estimate_t pending_estimates[$];
  int              mismatch_count = 0;
  int              words_sent     = 0;
  logic [DIST_W-1:0] last_range   = '0;
  logic            steady;

  // With R = 1 after reset, a first sample at exactly 400 cm leaves the mean
  // where it is, and the variance becomes 10000*1/(10000+1) truncated in
  // Q.12 (4095) plus ten times R (40960).
  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{1'b0, 10'd0,    16'd6400,  1'b1, 32'sd1638400, 32'd45055},
    '{1'b0, 10'd0,    16'h0000,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'hFFFF,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'hFFFF,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'h0000,  1'b0, 32'sd0,       32'd0},
    '{1'b1, 10'd1023, 16'hAAAA,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'h5555,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'h0000,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'hFFFF,  1'b0, 32'sd0,       32'd0},
    '{1'b1, 10'd0,    16'd1234,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'hFFFF,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'h0000,  1'b0, 32'sd0,       32'd0},
    '{1'b1, 10'd512,  16'h8000,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'h7FFF,  1'b0, 32'sd0,       32'd0},
    '{1'b1, 10'd1,    16'h0001,  1'b0, 32'sd0,       32'd0},
    '{1'b0, 10'd0,    16'hFFFE,  1'b0, 32'sd0,       32'd0}
  };

  scalar_kalman_range_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .distance_i  (distance_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .est_mean_o  (est_mean_o),
    .est_var_o   (est_var_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A long window in the middle of the run with no random idle cycles and no result stalls.
  assign steady = (words_sent >= 400) && (words_sent < 560);

  // Advances the predicted estimate by one distance sample and returns the
  // word the block should emit for it. A zero R behaves as one.
  function automatic range_estimate_t kalman_advance(input logic [DIST_W-1:0] range_cm);
    logic [63:0]     r_fix;
    logic [63:0]     mag;
    logic [127:0]    den;
    logic [127:0]    corr;
    logic [127:0]    pvar;
    logic [127:0]    var_sum;
    longint          z;
    longint          mu;
    longint          d;
    longint          mu_upd;
    longint          mean;
    range_estimate_t word;
    r_fix   = ((meas_var_q == '0) ? 64'd1 : 64'(meas_var_q)) << FRAC_BITS;
    z       = longint'(64'(range_cm) << (FRAC_BITS - DIST_FRAC));
    mu      = longint'(est_mean_q);
    d       = z - mu;
    mag     = (d < 0) ? 64'(-d) : 64'(d);
    den     = 128'(est_var_q) + 128'(r_fix);
    // The gain times the innovation, truncated toward zero in magnitude.
    corr    = (128'(est_var_q) * 128'(mag)) / den;
    mu_upd  = (d < 0) ? mu - longint'(corr[63:0]) : mu + longint'(corr[63:0]);
    // Predict: the motion mu' - z is added once more, then the mean saturates.
    mean    = 2 * mu_upd - z;
    if (mean > MEAN_MAX) mean = MEAN_MAX;
    if (mean < MEAN_MIN) mean = MEAN_MIN;
    pvar    = (128'(est_var_q) * 128'(r_fix)) / den;
    var_sum = pvar + 128'(PROC_VAR_SCALE) * 128'(r_fix);
    est_mean_q    = mean[VAL_W-1:0];
    est_var_q     = (var_sum > 128'hFFFF_FFFF) ? '1 : var_sum[VAL_W-1:0];
    word.mean     = est_mean_q;
    word.variance = est_var_q;
    return word;
  endfunction

  task automatic note_mismatch(input string field, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%t: %s mismatch, expected 0x%08h (%0d), got 0x%08h (%0d)",
               $realtime, field, want, want, got, got);
    end
  endtask

  // Presents one distance word, with the odd idle cycle before it, and
  // records its predicted estimate once the block has taken it.
  task automatic send_range(input logic [DIST_W-1:0] range_cm, input logic typed,
                            input range_estimate_t typed_word);
    range_estimate_t predicted;
    while (!steady && ($urandom_range(99) < 6)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    distance_i <= range_cm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = kalman_advance(range_cm);
    pending_estimates.push_back(typed ? typed_word : predicted);
    words_sent++;
    @(negedge clk_i);
  endtask

  // R is to change only with the block idle (not checked), so all results must be back first.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_meas_var(input logic [RVAR_W-1:0] r_value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r_value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    meas_var_q   = r_value;
  endtask

  // The result side stalls now and then, except inside the steady window.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 6);
  end

  // Every word the block hands over is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    range_estimate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_estimates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("%t: result word with none expected, mean 0x%08h, variance 0x%08h",
                   $realtime, est_mean_o, est_var_o);
        end
      end else begin
        want = pending_estimates.pop_front();
        if (est_mean_o !== want.mean) note_mismatch("est_mean", want.mean, est_mean_o);
        if (est_var_o !== want.variance) note_mismatch("est_var", want.variance, est_var_o);
      end
    end
  end

  initial begin : stimulus
    logic [63:0]       var_reset;
    logic [RVAR_W-1:0] r_pick;
    int                step;
    int                mode;
    int                target;
    // Predictor state after reset: mean 400, variance 10000, R one.
    var_reset  = 64'(VAR_RESET_WHOLE) << FRAC_BITS;
    est_mean_q = VAL_W'(64'(MEAN_RESET_WHOLE) << FRAC_BITS);
    est_var_q  = (var_reset > 64'hFFFF_FFFF) ? '1 : var_reset[VAL_W-1:0];
    meas_var_q = RVAR_W'(RVAR_RESET);

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: extremes of the distance, alternating bit patterns,
    // the largest and smallest R, and a zero R that must act as one.
    for (int row = 0; row < NUM_ROWS; row++) begin
      if (directed_rows[row].load_r) begin
        drain_block();
        load_meas_var(directed_rows[row].r_value);
      end
      send_range(directed_rows[row].range_cm, directed_rows[row].typed,
                 {directed_rows[row].mean, directed_rows[row].variance});
    end
    last_range = directed_rows[NUM_ROWS-1].range_cm;

    // Random part: each phase runs with its own R. Most samples track a
    // slowly moving target as a real range finder would; the rest are jumps,
    // full-range noise and the two end values.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       r_pick = '1;
        1:       r_pick = RVAR_W'(1);
        2:       r_pick = '0;
        default: r_pick = RVAR_W'($urandom_range(1023, 1));
      endcase
      drain_block();
      load_meas_var(r_pick);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        mode = $urandom_range(99);
        if (mode < 60) begin
          step   = int'($urandom_range(512)) - 256;
          target = int'(last_range) + step;
          if (target < 0) target = 0;
          if (target > 65535) target = 65535;
          last_range = DIST_W'(target);
        end else if (mode < 80) begin
          last_range = DIST_W'($urandom_range(65535));
        end else if (mode < 90) begin
          last_range = ($urandom_range(1) != 0) ? '1 : '0;
        end else begin
          last_range = last_range ^ DIST_W'($urandom_range(65535, 4096));
        end
        send_range(last_range, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // About ten times the slowest expected run.
  initial begin : watchdog
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/skrf_pkg.sv
rtl/skrf_mul.sv
rtl/skrf_div.sv
rtl/scalar_kalman_range_filter.sv
sim/scalar_kalman_range_filter_tb.sv
